[rtl/core/obstacle_risk_force_field_macros.svh]
// Assertion macros shared by the checker of the obstacle risk force field.
`ifndef OBSTACLE_RISK_FORCE_FIELD_MACROS_SVH
`define OBSTACLE_RISK_FORCE_FIELD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORFF_AST_IMP(lbl, ck, rstn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |-> (post)) \
		else $error("orff assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ORFF_AST_NXT(lbl, ck, rstn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |=> (post)) \
		else $error("orff assertion failed");

`endif

[rtl/core/orff_pkg.sv]
// Types and constants shared by the obstacle risk force field modules.
package orff_pkg;

	// Field and datapath widths.
	localparam int CoordW  = 16;
	localparam int GainW   = 16;
	localparam int DistW   = 16;
	localparam int StopW   = 22;
	localparam int NumW    = 33;
	localparam int RiskW   = 15;
	localparam int QuoW    = 14;
	localparam int ResDivW = 22;

	// Square root cell widths and cell count.
	localparam int SqRemW  = 18;
	localparam int SqRadW  = 32;
	localparam int SqCells = SqRadW / 2;

	// Force division: product width and the split into remainder and shifted bits.
	localparam int ProdW    = 30;
	localparam int FcCells  = 15;

	// Register defaults and fixed values.
	localparam logic [GainW-1:0] GainReset = 16'd256;
	localparam logic [RiskW-1:0] RiskOne   = 15'd16384;
	localparam logic signed [16:0] VelOne  = 17'sd256;

	// Sideband carried along the square root chain.
	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic [StopW-1:0]         stop;
		logic                     vpos;
		logic                     nonpos;
		logic signed [NumW-1:0]   num;
		logic                     zero;
	} sq_side_t;

	// Sideband carried along the risk division chain.
	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic [DistW-1:0]         d;
		logic                     zero;
		logic                     full;
		logic                     nonpos;
	} rk_side_t;

	// Sideband carried along each force division chain.
	typedef struct packed {
		logic [RiskW-1:0] risk;
		logic             zero;
		logic             pos;
	} fc_side_t;

endpackage

[rtl/core/orff_sqrt_cell.sv]
// One cell of the integer square root chain: resolves one root bit per cycle while en is high.
module orff_sqrt_cell import orff_pkg::*; #(
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [SqRemW-1:0] in_rem,
	input  logic [DistW-1:0]  in_root,
	input  logic [SqRadW-1:0] in_rad,
	input  logic [SW-1:0]     in_side,
	output logic              out_vld,
	output logic [SqRemW-1:0] out_rem,
	output logic [DistW-1:0]  out_root,
	output logic [SqRadW-1:0] out_rad,
	output logic [SW-1:0]     out_side
);

	logic [SqRemW+1:0] t;
	logic [SqRemW+1:0] trial;
	logic [SqRemW+1:0] diff;
	logic              ge;
	logic              vld_q;
	logic [SqRemW-1:0] rem_q;
	logic [DistW-1:0]  root_q;
	logic [SqRadW-1:0] rad_q;
	logic [SW-1:0]     side_q;

	// Bring in the next two radicand bits and try the trial subtrahend.
	always_comb begin
		t     = {in_rem, in_rad[SqRadW-1 -: 2]};
		trial = {2'b00, in_root, 2'b01};
		diff  = t - trial;
		ge    = (t >= trial);
	end

	// Valid bit of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	// Partial remainder, root and remaining radicand bits.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[SqRemW-1:0] : t[SqRemW-1:0];
			root_q <= {in_root[DistW-2:0], ge};
			rad_q  <= {in_rad[SqRadW-3:0], 2'b00};
			side_q <= in_side;
		end
	end

	assign out_vld  = vld_q;
	assign out_rem  = rem_q;
	assign out_root = root_q;
	assign out_rad  = rad_q;
	assign out_side = side_q;

endmodule

[rtl/core/orff_div_cell.sv]
// One cell of a restoring division chain: resolves one quotient bit per cycle while en is high.
module orff_div_cell import orff_pkg::*; #(
	parameter int DW = 16,
	parameter int NW = 15,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW-1:0] in_rem,
	input  logic [NW-1:0] in_dq,
	input  logic [DW-1:0] in_dvs,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [DW-1:0] out_rem,
	output logic [NW-1:0] out_dq,
	output logic [DW-1:0] out_dvs,
	output logic [SW-1:0] out_side
);

	logic [DW:0]   t;
	logic [DW:0]   diff;
	logic          ge;
	logic          vld_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] dq_q;
	logic [DW-1:0] dvs_q;
	logic [SW-1:0] side_q;

	// Shift in the next dividend bit and compare against the divisor.
	always_comb begin
		t    = {in_rem, in_dq[NW-1]};
		diff = t - {1'b0, in_dvs};
		ge   = (t >= {1'b0, in_dvs});
	end

	// Valid bit of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	// Remainder, dividend/quotient shift word, divisor and sideband.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[DW-1:0] : t[DW-1:0];
			dq_q   <= {in_dq[NW-2:0], ge};
			dvs_q  <= in_dvs;
			side_q <= in_side;
		end
	end

	assign out_vld  = vld_q;
	assign out_rem  = rem_q;
	assign out_dq   = dq_q;
	assign out_dvs  = dvs_q;
	assign out_side = side_q;

endmodule

[rtl/core/obstacle_risk_force_field.sv]
// Top level of the obstacle risk force field: a chain of root and divider cells.
//
//  Channel  | Dir | Signals                          | Beat contents
//  ---------+-----+----------------------------------+------------------------------------
//  s_axis   | in  | tvalid tready tdata[63:0]        | obs_x, obs_y, obs_z, vel_x
//  m_axis   | out | tvalid tready tdata[63:0] tuser  | force_x/y/z, risk_level; zero_distance
//  cfg      | in  | valid ready data[15:0]           | risk_gain
//
// One beat is accepted per cycle unless m_axis stalls; each beat passes in order through stages 1 and 2,
// the 16 square root cells, stage 3, the 14 risk division cells, stage 4, the 15 force division cells
// and the output register: five plain pipeline registers beside the cells.
// Reset clears all valid bits and loads risk_gain with 1.0; cfg is always ready.
// A stall on m_axis freezes the whole chain and drops s_axis_tready in the same cycle.
module obstacle_risk_force_field import orff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // obs_x[15:0], obs_y[31:16], obs_z[47:32], vel_x[63:48]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // force_x[15:0], force_y[31:16], force_z[47:32],
	                                    // risk_level[62:48], zero fill[63]
	output logic        m_axis_tuser,   // zero_distance[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int SqSW = $bits(sq_side_t);
	localparam int RkSW = $bits(rk_side_t);
	localparam int FcSW = $bits(fc_side_t);

	logic             adv;
	logic [GainW-1:0] gain_q;
	logic             out_vld_q;
	logic [63:0]      out_data_q;
	logic             out_user_q;

	// Whole chain advances unless a finished result is held back.
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	// Gain register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GainReset;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	// Stage 1: unpack the beat and form the squares.
	logic signed [CoordW-1:0]   in_x, in_y, in_z, in_v;
	logic signed [2*CoordW-1:0] xx_w, yy_w, zz_w, vv_w;
	logic                       vld_s1;
	logic signed [CoordW-1:0]   x_s1, y_s1, z_s1, v_s1;
	logic [30:0]                xx_s1, yy_s1, zz_s1, vv_s1;

	always_comb begin
		in_x = s_axis_tdata[15:0];
		in_y = s_axis_tdata[31:16];
		in_z = s_axis_tdata[47:32];
		in_v = s_axis_tdata[63:48];
		xx_w = in_x * in_x;
		yy_w = in_y * in_y;
		zz_w = in_z * in_z;
		vv_w = in_v * in_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= in_x;
			y_s1  <= in_y;
			z_s1  <= in_z;
			v_s1  <= in_v;
			xx_s1 <= xx_w[30:0];
			yy_s1 <= yy_w[30:0];
			zz_s1 <= zz_w[30:0];
			vv_s1 <= vv_w[30:0];
		end
	end

	// Stage 2: squared distance, stopping distance and risk numerator.
	logic signed [16:0]       nv_w;
	logic signed [34:0]       num_w;
	logic                     vld_s2;
	logic [SqRadW-1:0]        d2_s2;
	sq_side_t                 sq_in_s2;

	always_comb begin
		nv_w  = {v_s1[CoordW-1], v_s1} + VelOne;
		num_w = $signed({1'b0, gain_q}) * nv_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s2           <= {1'b0, xx_s1} + {1'b0, yy_s1} + {1'b0, zz_s1};
			sq_in_s2.x      <= x_s1;
			sq_in_s2.y      <= y_s1;
			sq_in_s2.z      <= z_s1;
			sq_in_s2.stop   <= vv_s1[30:9];
			sq_in_s2.vpos   <= !v_s1[CoordW-1] && (v_s1 != '0);
			sq_in_s2.nonpos <= nv_w[16] || (nv_w == '0);
			sq_in_s2.num    <= num_w[NumW-1:0];
			sq_in_s2.zero   <= (x_s1 == '0) && (y_s1 == '0) && (z_s1 == '0);
		end
	end

	// Square root chain.
	logic              sq_vld  [0:SqCells];
	logic [SqRemW-1:0] sq_rem  [0:SqCells];
	logic [DistW-1:0]  sq_root [0:SqCells];
	logic [SqRadW-1:0] sq_rad  [0:SqCells];
	logic [SqSW-1:0]   sq_side [0:SqCells];

	assign sq_vld[0]  = vld_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = d2_s2;
	assign sq_side[0] = sq_in_s2;

	for (genvar i = 0; i < SqCells; i++) begin : g_sq
		orff_sqrt_cell #(.SW(SqSW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_vld   (sq_vld[i]),
			.in_rem   (sq_rem[i]),
			.in_root  (sq_root[i]),
			.in_rad   (sq_rad[i]),
			.in_side  (sq_side[i]),
			.out_vld  (sq_vld[i+1]),
			.out_rem  (sq_rem[i+1]),
			.out_root (sq_root[i+1]),
			.out_rad  (sq_rad[i+1]),
			.out_side (sq_side[i+1])
		);
	end

	// Stage 3: residual distance and the full-risk test.
	sq_side_t           sq_out;
	logic signed [23:0] res_w;
	logic signed [33:0] res_sh_w;
	logic signed [33:0] num_x_w;
	logic               full_w;
	logic               vld_s3;
	logic [ResDivW-1:0] rem_s3;
	logic [QuoW-1:0]    dq_s3;
	logic [ResDivW-1:0] dvs_s3;
	rk_side_t           rk_in_s3;

	always_comb begin
		sq_out   = sq_side[SqCells];
		res_w    = sq_out.vpos ?
			$signed({8'b0, sq_root[SqCells]}) - $signed({2'b0, sq_out.stop}) :
			$signed({8'b0, sq_root[SqCells]}) + $signed({2'b0, sq_out.stop});
		res_sh_w = {{2{res_w[23]}}, res_w, 8'b0};
		num_x_w  = {sq_out.num[NumW-1], sq_out.num};
		full_w   = res_w[23] || (res_w == '0) || (num_x_w >= res_sh_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= sq_vld[SqCells];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s3          <= sq_out.num[29:8];
			dq_s3           <= {sq_out.num[7:0], 6'b0};
			dvs_s3          <= res_w[ResDivW-1:0];
			rk_in_s3.x      <= sq_out.x;
			rk_in_s3.y      <= sq_out.y;
			rk_in_s3.z      <= sq_out.z;
			rk_in_s3.d      <= sq_root[SqCells];
			rk_in_s3.zero   <= sq_out.zero;
			rk_in_s3.full   <= full_w;
			rk_in_s3.nonpos <= sq_out.nonpos;
		end
	end

	// Risk division chain.
	logic               rk_vld  [0:QuoW];
	logic [ResDivW-1:0] rk_rem  [0:QuoW];
	logic [QuoW-1:0]    rk_dq   [0:QuoW];
	logic [ResDivW-1:0] rk_dvs  [0:QuoW];
	logic [RkSW-1:0]    rk_side [0:QuoW];

	assign rk_vld[0]  = vld_s3;
	assign rk_rem[0]  = rem_s3;
	assign rk_dq[0]   = dq_s3;
	assign rk_dvs[0]  = dvs_s3;
	assign rk_side[0] = rk_in_s3;

	for (genvar i = 0; i < QuoW; i++) begin : g_rk
		orff_div_cell #(.DW(ResDivW), .NW(QuoW), .SW(RkSW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_vld   (rk_vld[i]),
			.in_rem   (rk_rem[i]),
			.in_dq    (rk_dq[i]),
			.in_dvs   (rk_dvs[i]),
			.in_side  (rk_side[i]),
			.out_vld  (rk_vld[i+1]),
			.out_rem  (rk_rem[i+1]),
			.out_dq   (rk_dq[i+1]),
			.out_dvs  (rk_dvs[i+1]),
			.out_side (rk_side[i+1])
		);
	end

	// Stage 4: final risk and the scaled magnitudes of the three components.
	rk_side_t         rk_out;
	logic [RiskW-1:0] risk_w;
	logic [CoordW-1:0] mag_x, mag_y, mag_z;
	logic [30:0]      px_w, py_w, pz_w;
	logic             vld_s4;
	logic [ProdW-1:0] px_s4, py_s4, pz_s4;
	logic [DistW-1:0] d_s4;
	fc_side_t         fx_s4, fy_s4, fz_s4;

	always_comb begin
		rk_out = rk_side[QuoW];
		priority if (rk_out.full) begin
			risk_w = RiskOne;
		end else if (rk_out.nonpos) begin
			risk_w = '0;
		end else begin
			risk_w = {1'b0, rk_dq[QuoW]};
		end
		mag_x = rk_out.x[CoordW-1] ? CoordW'(-rk_out.x) : rk_out.x;
		mag_y = rk_out.y[CoordW-1] ? CoordW'(-rk_out.y) : rk_out.y;
		mag_z = rk_out.z[CoordW-1] ? CoordW'(-rk_out.z) : rk_out.z;
		px_w  = mag_x * risk_w;
		py_w  = mag_y * risk_w;
		pz_w  = mag_z * risk_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= rk_vld[QuoW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4      <= px_w[ProdW-1:0];
			py_s4      <= py_w[ProdW-1:0];
			pz_s4      <= pz_w[ProdW-1:0];
			d_s4       <= rk_out.d;
			fx_s4.risk <= risk_w;
			fx_s4.zero <= rk_out.zero;
			fx_s4.pos  <= !rk_out.x[CoordW-1] && (rk_out.x != '0);
			fy_s4.risk <= risk_w;
			fy_s4.zero <= rk_out.zero;
			fy_s4.pos  <= !rk_out.y[CoordW-1] && (rk_out.y != '0);
			fz_s4.risk <= risk_w;
			fz_s4.zero <= rk_out.zero;
			fz_s4.pos  <= !rk_out.z[CoordW-1] && (rk_out.z != '0);
		end
	end

	// Three force division chains, one per axis, dividing by the distance.
	logic [ProdW-1:0] p_s4 [0:2];
	fc_side_t         f_s4 [0:2];
	logic [RiskW-1:0] fq   [0:2];
	fc_side_t         fs   [0:2];
	logic             fv   [0:2];

	assign p_s4[0] = px_s4;
	assign p_s4[1] = py_s4;
	assign p_s4[2] = pz_s4;
	assign f_s4[0] = fx_s4;
	assign f_s4[1] = fy_s4;
	assign f_s4[2] = fz_s4;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic             fc_vld  [0:FcCells];
		logic [DistW-1:0] fc_rem  [0:FcCells];
		logic [RiskW-1:0] fc_dq   [0:FcCells];
		logic [DistW-1:0] fc_dvs  [0:FcCells];
		logic [FcSW-1:0]  fc_side [0:FcCells];

		assign fc_vld[0]  = vld_s4;
		assign fc_rem[0]  = DistW'(p_s4[a][ProdW-1:FcCells]);
		assign fc_dq[0]   = p_s4[a][FcCells-1:0];
		assign fc_dvs[0]  = d_s4;
		assign fc_side[0] = f_s4[a];

		for (genvar i = 0; i < FcCells; i++) begin : g_fc
			orff_div_cell #(.DW(DistW), .NW(RiskW), .SW(FcSW)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (adv),
				.in_vld   (fc_vld[i]),
				.in_rem   (fc_rem[i]),
				.in_dq    (fc_dq[i]),
				.in_dvs   (fc_dvs[i]),
				.in_side  (fc_side[i]),
				.out_vld  (fc_vld[i+1]),
				.out_rem  (fc_rem[i+1]),
				.out_dq   (fc_dq[i+1]),
				.out_dvs  (fc_dvs[i+1]),
				.out_side (fc_side[i+1])
			);
		end

		assign fq[a] = fc_dq[FcCells];
		assign fs[a] = fc_side[FcCells];
		assign fv[a] = fc_vld[FcCells];
	end

	// Output register: apply signs, zero-distance override and pack the beat.
	logic [CoordW-1:0] force_w [0:2];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (fs[a].zero) begin
				force_w[a] = '0;
			end else if (fs[a].pos) begin
				force_w[a] = CoordW'(-{1'b0, fq[a]});
			end else begin
				force_w[a] = {1'b0, fq[a]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= fv[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {1'b0, fs[0].risk, force_w[2], force_w[1], force_w[0]};
			out_user_q <= fs[0].zero;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// The other two chains run in lock step with the first.
	logic unused_vld;
	assign unused_vld = fv[1] ^ fv[2];

endmodule

[rtl/core/orff_checker.sv]
// Port-level checker for the obstacle risk force field, bound to the top level.
`include "obstacle_risk_force_field_macros.svh"

module orff_checker import orff_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A result beat held back by the sink keeps its contents.
	`ORFF_AST_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// A point at the origin produces no force.
	`ORFF_AST_IMP(a_zero_force, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[47:0] == 48'd0)

	// Risk never exceeds one and the fill bit stays clear.
	`ORFF_AST_IMP(a_risk_range, clk, arst_n, m_axis_tvalid, (m_axis_tdata[62:48] <= RiskOne) && !m_axis_tdata[63])

	// Input back-pressure only comes from a stalled result beat.
	`ORFF_AST_IMP(a_in_stall, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind obstacle_risk_force_field orff_checker u_orff_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

[tb/tb_obstacle_risk_force_field.sv]
// Self-checking testbench for the obstacle risk force field pipeline.
module tb_obstacle_risk_force_field;
	import orff_pkg::*;

	// One obstacle beat and one force beat.
	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] pz;
		logic signed [15:0] py;
		logic signed [15:0] px;
	} point_t;

	typedef struct {
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fz;
		logic [14:0] risk;
		logic        zero;
	} force_t;

	localparam int Latency = 50;
	localparam int CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	point_t      pending_points[$];
	force_t      expected_forces[$];
	logic [15:0] gain_now;
	int          error_count;
	int          cycle_count;
	bit          calm_phase;
	int          send_gap;
	int          recv_gap;
	int          hold_off;

	obstacle_risk_force_field u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Integer square root, floor.
	function automatic longint floor_sqrt(longint n);
		longint r;
		r = 0;
		for (longint b = 32'h8000; b > 0; b = b >> 1) begin
			if ((r + b) * (r + b) <= n)
				r = r + b;
		end
		return r;
	endfunction

	// Repulsive force component: magnitude truncated, sign opposite to p.
	function automatic logic [15:0] repel(longint p, longint risk, longint d);
		longint q;
		q = ((p < 0 ? -p : p) * risk) / d;
		return (p > 0) ? 16'(-q) : 16'(q);
	endfunction

	// Expected force and risk for one point under the current gain.
	function automatic force_t predict_force(point_t pt, logic [15:0] gain);
		force_t f;
		longint x, y, z, v, d2, d, stp, res, nv, num, risk;
		x = pt.px; y = pt.py; z = pt.pz; v = pt.vx;
		d2 = x * x + y * y + z * z;
		d2 = d2 & 64'hFFFF_FFFF;
		d = floor_sqrt(d2);
		stp = (v * v) >>> 9;
		res = (v <= 0) ? d + stp : d - stp;
		nv = 256 + v;
		num = longint'(gain) * nv;
		if (res <= 0 || num >= res * 256)
			risk = 16384;
		else if (nv <= 0)
			risk = 0;
		else
			risk = (num * 64) / res;
		if (d2 == 0) begin
			f.fx = 0; f.fy = 0; f.fz = 0; f.zero = 1'b1;
		end else begin
			f.fx = repel(x, risk, d);
			f.fy = repel(y, risk, d);
			f.fz = repel(z, risk, d);
			f.zero = 1'b0;
		end
		f.risk = risk[14:0];
		return f;
	endfunction

	function automatic point_t rand_point();
		point_t pt;
		int sel;
		sel = $urandom_range(0, 9);
		pt = point_t'({$urandom, $urandom});
		// Mostly realistic ranges so that the risk lands in between its extremes.
		if (sel < 6) begin
			pt.px = 16'($signed($urandom_range(0, 4000)) - 2000);
			pt.py = 16'($signed($urandom_range(0, 4000)) - 2000);
			pt.pz = 16'($signed($urandom_range(0, 4000)) - 2000);
			pt.vx = 16'($signed($urandom_range(0, 1000)) - 500);
		end else if (sel == 6) begin
			pt.px = 0; pt.py = 0; pt.pz = 0;
		end
		return pt;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Driver: offers queued points with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_forces.push_back(predict_force(point_t'(s_axis_tdata), gain_now));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					s_axis_tdata  <= pending_points.pop_front();
					s_axis_tvalid <= 1'b1;
					if (!calm_phase && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 7);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver back pressure, with one long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= 0;
		end else if (hold_off > 0) begin
			hold_off      <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap      <= recv_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm_phase && $urandom_range(0, 5) == 0)
				recv_gap <= $urandom_range(1, 7);
		end
	end

	// Monitor: compares each force beat with the oldest expectation.
	always @(posedge clk) begin
		force_t exp_f;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_forces.size() == 0) begin
				$display("%0t unexpected beat %h", $time, m_axis_tdata);
				error_count <= error_count + 1;
			end else begin
				exp_f = expected_forces.pop_front();
				if (m_axis_tdata[15:0] !== exp_f.fx || m_axis_tdata[31:16] !== exp_f.fy
						|| m_axis_tdata[47:32] !== exp_f.fz
						|| m_axis_tdata[62:48] !== exp_f.risk
						|| m_axis_tuser !== exp_f.zero) begin
					$display("%0t mismatch: expected fx %h fy %h fz %h risk %h zero %b, actual %h zero %b",
						$time, exp_f.fx, exp_f.fy, exp_f.fz, exp_f.risk, exp_f.zero,
						m_axis_tdata, m_axis_tuser);
					error_count <= error_count + 1;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_gain(logic [15:0] g);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= g;
		do @(posedge clk); while (!cfg_ready);
		gain_now = g;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_points.size() == 0);
		@(posedge clk);
		while (s_axis_tvalid || expected_forces.size() > 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
	endtask

	// Stimulus.
	initial begin
		logic [15:0] gains[6];
		point_t pt;
		gains = '{16'd0, 16'd65535, 16'd1, 16'd64, 16'd1024, 16'd256};
		error_count = 0;
		cycle_count = 0;
		calm_phase = 1'b0;
		hold_off = 0;
		gain_now = GainReset;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed points at reset gain: origin, extremes, velocity corners.
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_points.push_back('{-16'sd256, 16'sd0, 16'sd0, 16'sd0});
		pending_points.push_back('{16'sd512, 16'sd0, 16'sd0, 16'sd0});
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd1000});
		pending_points.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
		pending_points.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
		pending_points.push_back('{-16'sd32768, 16'sd32767, 16'sd0, 16'sd0});
		pending_points.push_back('{-16'sd256, 16'sd100, -16'sd300, 16'sd2560});
		pending_points.push_back('{-16'sd300, 16'sd1000, -16'sd700, 16'sd1500});
		pending_points.push_back('{16'sd100, 16'sd1000, 16'sd3000, -16'sd1});
		pending_points.push_back('{-16'sd400, -16'sd400, -16'sd400, 16'sd4000});
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd200});
		pending_points.push_back('{16'sd50, 16'sd1, 16'sd1, 16'sd1});
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd256});
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd1});
		drain();

		// Phases under several gains; a long output stall in the first one.
		foreach (gains[i]) begin
			write_gain(gains[i]);
			pending_points.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
			pending_points.push_back('{-16'sd300, 16'sd1000, -16'sd700, 16'sd1500});
			pending_points.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd200});
			if (i == 5)
				calm_phase = 1'b1;
			for (int k = 0; k < 180; k++) begin
				pt = rand_point();
				pending_points.push_back(pt);
			end
			if (i == 0) begin
				repeat (20) @(posedge clk);
				hold_off = 300;
			end
			drain();
		end

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/orff_pkg.sv
rtl/core/orff_sqrt_cell.sv
rtl/core/orff_div_cell.sv
rtl/core/obstacle_risk_force_field.sv
rtl/core/orff_checker.sv
tb/tb_obstacle_risk_force_field.sv
